// File: hw/rtl/kpd_pkg.sv
package kpd_pkg;

   localparam int NOW_W      = 32;
   localparam int MASK_W     = 16;
   localparam int HOLD_W     = 16;
   localparam int POS_W      = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 8;

   localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd200;

   typedef struct packed {
      logic             push;
      logic             flush;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } kpd_evt_type;

   typedef struct packed {
      logic ready;
      logic pend_vld;
   } kpd_sts_type;

endpackage

// File: hw/rtl/kpd_time_ram.sv
module kpd_time_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [AW-1:0]              waddr,
   input  logic [kpd_pkg::NOW_W-1:0]  wdata,
   input  logic                       re,
   input  logic [AW-1:0]              raddr,
   output logic [kpd_pkg::NOW_W-1:0]  rdata
);

   logic [kpd_pkg::NOW_W-1:0] time_mem [DEPTH];
   logic [kpd_pkg::NOW_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         time_mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= time_mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/kpd_scan.sv
module kpd_scan #(
   parameter int KEY_ROWS = 4,
   parameter int NKEY     = 16,
   parameter int IDX_W    = 4,
   parameter int ROW_W    = 2,
   parameter int COL_W    = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [kpd_pkg::NOW_W-1:0]   now_ms,
   input  logic [kpd_pkg::MASK_W-1:0]  pressed_mask,
   input  logic [kpd_pkg::HOLD_W-1:0]  hold_ms,
   output logic                        mem_we,
   output logic [IDX_W-1:0]            mem_waddr,
   output logic [kpd_pkg::NOW_W-1:0]   mem_wdata,
   output logic                        mem_re,
   output logic [IDX_W-1:0]            mem_raddr,
   input  logic [kpd_pkg::NOW_W-1:0]   mem_rdata,
   output kpd_pkg::kpd_evt_type        evt,
   input  kpd_pkg::kpd_sts_type        sts
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [IDX_W-1:0]            key_ff, key_in;
   logic [ROW_W-1:0]            row_ff, row_in;
   logic [COL_W-1:0]            col_ff, col_in;
   logic [NKEY-1:0]             armed_ff, armed_in;
   logic [kpd_pkg::NOW_W-1:0]   now_ff;
   logic [kpd_pkg::MASK_W-1:0]  mask_ff;

   logic                        accept;
   logic                        down;
   logic                        armed;
   logic                        hit;
   logic                        advance;
   logic                        last_key;
   logic [kpd_pkg::NOW_W-1:0]   start;
   logic [kpd_pkg::NOW_W-1:0]   elapsed;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign down     = mask_ff[key_ff];
   assign armed    = armed_ff[key_ff];
   assign start    = armed ? mem_rdata : now_ff;
   assign elapsed  = now_ff - start;
   assign hit      = down && (elapsed >= {{(kpd_pkg::NOW_W-kpd_pkg::HOLD_W){1'b0}}, hold_ms});
   assign advance  = (state_ff == ST_RUN) && (!hit || sts.ready);
   assign last_key = (key_ff == IDX_W'(NKEY - 1));

   assign mem_we    = advance && down && !armed;
   assign mem_waddr = key_ff;
   assign mem_wdata = now_ff;
   assign mem_re    = accept || (advance && !last_key);
   assign mem_raddr = accept ? '0 : key_ff + IDX_W'(1);

   assign evt.push  = advance && hit;
   assign evt.flush = (state_ff == ST_FLUSH) && sts.ready;
   assign evt.row   = row_ff[kpd_pkg::POS_W-1:0];
   assign evt.col   = col_ff[kpd_pkg::POS_W-1:0];

   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      armed_in = armed_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               key_in   = '0;
               row_in   = '0;
               col_in   = '0;
            end
         end
         ST_RUN: begin
            if (advance) begin
               armed_in[key_ff] = !hit && (armed || down);
               if (last_key) begin
                  state_in = ST_FLUSH;
               end else begin
                  key_in = key_ff + IDX_W'(1);
                  if (row_ff == ROW_W'(KEY_ROWS - 1)) begin
                     row_in = '0;
                     col_in = col_ff + COL_W'(1);
                  end else begin
                     row_in = row_ff + ROW_W'(1);
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (sts.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         armed_ff <= '0;
      end else begin
         state_ff <= state_in;
         armed_ff <= armed_in;
      end
      key_ff <= key_in;
      row_ff <= row_in;
      col_ff <= col_in;
      if (accept) begin
         now_ff  <= now_ms;
         mask_ff <= pressed_mask;
      end
   end

endmodule

// File: hw/rtl/kpd_evt_out.sv
module kpd_evt_out (
   input  logic                        clock,
   input  logic                        reset,
   input  kpd_pkg::kpd_evt_type        evt,
   output kpd_pkg::kpd_sts_type        sts,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [kpd_pkg::POS_W-1:0]   key_row,
   output logic [kpd_pkg::POS_W-1:0]   key_col,
   output logic                        last_event
);

   logic                       pend_vld_ff, pend_vld_in;
   logic [kpd_pkg::POS_W-1:0]  pend_row_ff;
   logic [kpd_pkg::POS_W-1:0]  pend_col_ff;
   logic                       out_vld_ff, out_vld_in;
   logic [kpd_pkg::POS_W-1:0]  out_row_ff;
   logic [kpd_pkg::POS_W-1:0]  out_col_ff;
   logic                       out_last_ff;
   logic                       out_free;
   logic                       move;

   assign out_free     = !out_vld_ff || rsp_tready;
   assign sts.ready    = !pend_vld_ff || out_free;
   assign sts.pend_vld = pend_vld_ff;
   assign move         = pend_vld_ff && (evt.push || evt.flush);

   always_comb begin
      out_vld_in  = out_vld_ff && !rsp_tready;
      pend_vld_in = pend_vld_ff;
      if (move) begin
         out_vld_in = 1'b1;
      end
      if (evt.push) begin
         pend_vld_in = 1'b1;
      end else if (evt.flush) begin
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
      if (evt.push) begin
         pend_row_ff <= evt.row;
         pend_col_ff <= evt.col;
      end
      if (move) begin
         out_row_ff  <= pend_row_ff;
         out_col_ff  <= pend_col_ff;
         out_last_ff <= evt.flush;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign key_row    = out_row_ff;
   assign key_col    = out_col_ff;
   assign last_event = out_last_ff;

endmodule

// File: hw/rtl/keypad_hold_debounce.sv
// Channel  | Dir | Handshake             | Payload
// req      | in  | req_tvalid/req_tready | tdata: now_ms[31:0], pressed_mask[47:32]
// rsp      | out | rsp_tvalid/rsp_tready | tdata: key_row[1:0], key_col[3:2]; tlast: last_event
// csr      | in  | csr_we                | csr_wdata: hold_ms
//
// An item is taken in an accept cycle; the walk then steps through the keys
// (KEY_ROWS*KEY_COLS keys, capped at sixteen) over the single read port of the
// start-time memory, and a closing cycle ends it; no new item is taken before that.
// Each event waits in a holding register so the final one can carry tlast; while the
// holding and output registers are both full and rsp_tready is low, a key that reports
// stalls the walk and the closing cycle waits as well.
// Reset is synchronous and clears the armed flags, the control state and hold_ms to 200.
module keypad_hold_debounce #(
   parameter int KEY_ROWS = 4,
   parameter int KEY_COLS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [kpd_pkg::REQ_DATA_W-1:0]    req_tdata,   // now_ms, pressed_mask
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kpd_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // key_row, key_col, zero fill
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [kpd_pkg::HOLD_W-1:0]        csr_wdata
);

   localparam int KEYS  = KEY_ROWS * KEY_COLS;
   localparam int NKEY  = (KEYS > kpd_pkg::MASK_W) ? kpd_pkg::MASK_W : KEYS;
   localparam int IDX_W = (NKEY > 1) ? $clog2(NKEY) : 1;
   localparam int ROW_W = ($clog2(KEY_ROWS) > kpd_pkg::POS_W) ? $clog2(KEY_ROWS)
                                                               : kpd_pkg::POS_W;
   localparam int COL_W = ($clog2(KEY_COLS) > kpd_pkg::POS_W) ? $clog2(KEY_COLS)
                                                               : kpd_pkg::POS_W;

   logic [kpd_pkg::HOLD_W-1:0]  hold_ff;
   logic                        mem_we;
   logic [IDX_W-1:0]            mem_waddr;
   logic [kpd_pkg::NOW_W-1:0]   mem_wdata;
   logic                        mem_re;
   logic [IDX_W-1:0]            mem_raddr;
   logic [kpd_pkg::NOW_W-1:0]   mem_rdata;
   kpd_pkg::kpd_evt_type        evt;
   kpd_pkg::kpd_sts_type        sts;
   logic [kpd_pkg::POS_W-1:0]   key_row;
   logic [kpd_pkg::POS_W-1:0]   key_col;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= kpd_pkg::HOLD_RESET;
      end else if (csr_we) begin
         hold_ff <= csr_wdata;
      end
   end

   kpd_time_ram #(
      .DEPTH (NKEY),
      .AW    (IDX_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   kpd_scan #(
      .KEY_ROWS (KEY_ROWS),
      .NKEY     (NKEY),
      .IDX_W    (IDX_W),
      .ROW_W    (ROW_W),
      .COL_W    (COL_W)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .now_ms       (req_tdata[kpd_pkg::NOW_W-1:0]),
      .pressed_mask (req_tdata[kpd_pkg::NOW_W +: kpd_pkg::MASK_W]),
      .hold_ms      (hold_ff),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_re       (mem_re),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata),
      .evt          (evt),
      .sts          (sts)
   );

   kpd_evt_out u_out (
      .clock      (clock),
      .reset      (reset),
      .evt        (evt),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .key_row    (key_row),
      .key_col    (key_col),
      .last_event (rsp_tlast)
   );

   assign rsp_tdata = {{(kpd_pkg::RSP_DATA_W - 2*kpd_pkg::POS_W){1'b0}}, key_col, key_row};

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("new item taken while a scan is in progress");

   a_no_pending_when_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !sts.pend_vld)
      else $error("event left in the holding register after the scan ended");

   a_no_write_read_clash: assert property (@(posedge clock) disable iff (reset)
      mem_we && mem_re |-> mem_waddr != mem_raddr)
      else $error("start-time memory read and written at the same entry");

   a_flush_clears_pending: assert property (@(posedge clock) disable iff (reset)
      evt.flush |=> !sts.pend_vld)
      else $error("holding register still full after the closing cycle");

endmodule
